### rtl/vma_pkg.sv
// shared types and constants of the voice mix accumulator
`default_nettype none

package vma_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_MIX   = 2'd1,
        REQ_DRAIN = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SPEAKER_COUNT = 2'd0;
    localparam logic [1:0] CFG_OUT_16BIT     = 2'd1;
    localparam logic [1:0] CFG_RING_SIZE     = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int ACC_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 8;
    localparam int PROD_W     = SAMPLE_W + VOL_W + 1;
    localparam int FRAME_W    = 11;
    localparam int SPK_W      = 3;
    localparam int CNT_W      = 4;
    localparam int RING_W     = 16;
    localparam int LIM_W      = 17;

    // stream widths
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;

    localparam logic [LIM_W-1:0] RING_FULL  = 17'h10000;
    localparam logic [ACC_W-1:0] ACC_MAX    = 32'h7fff_ffff;
    localparam logic [ACC_W-1:0] ACC_MIN    = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] CLIP_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] CLIP_MIN = 16'h8000;

endpackage

`default_nettype wire

### rtl/voice_mix_accumulator.sv
// top level of the voice mix accumulator: mix store, request sequencer, drain output
//
// input channel s_*: one transaction is one request (clear, mix or drain of one
// frame); the kind travels in s_tuser, the frame, samples and volumes in s_tdata.
// output channel m_*: one transaction per active speaker of a drained frame,
// speaker 0 first, m_tlast on the last speaker of the frame.
// config port: cfg_wr_en writes cfg_data into register cfg_index; the user must
// write only while no request is in flight, the block does not enforce it.
// the mix store is one synchronous memory with a frame per row (all speakers
// side by side) and a registered read; each mix or drain costs one read of a row.
// clear: the row is written at the accepting edge.
// mix: row read on the accepting edge, saturating adds and write back on the
// next; the registered read and the write-back interlock set this order.
// drain: row read, then one output per cycle while the receiver takes them;
// m_tvalid is set in ST_EMIT after the row read, once the output register is free.
// the output register lets the next request be taken while a drained sample
// waits; a stalled receiver holds the drain, and s_tready stays low until the
// last speaker has entered the output register.
// reset clears control and the ring position and sets the config registers to
// their defaults; the store itself is undefined until each frame is cleared once.
`default_nettype none

module voice_mix_accumulator #(
    parameter int FRAMES   = 2048,
    parameter int SPEAKERS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata: frame_index, sample_left, sample_right, volumes_packed, zero pad
    input  wire logic [vma_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: req_type, source_8bit, source_stereo
    input  wire logic [vma_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: out_sample, out_index, speaker, zero pad
    output logic [vma_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [vma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vma_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(FRAMES);
    localparam int SW    = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
    localparam int ROW_W = SPEAKERS * vma_pkg::ACC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_EMIT
    } state_t;

    // ---------------- config registers ----------------
    logic [vma_pkg::CNT_W-1:0]  speaker_count_reg;
    logic                       out_16bit_reg;
    logic [vma_pkg::LIM_W-1:0]  ring_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speaker_count_reg <= 4'd2;
            out_16bit_reg     <= 1'b1;
            ring_size_reg     <= vma_pkg::RING_FULL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vma_pkg::CFG_SPEAKER_COUNT: speaker_count_reg <= cfg_data[vma_pkg::CNT_W-1:0];
                vma_pkg::CFG_OUT_16BIT:     out_16bit_reg     <= cfg_data[0];
                vma_pkg::CFG_RING_SIZE:     ring_size_reg     <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // active speakers, clamped to 1..SPEAKERS
    logic [vma_pkg::CNT_W-1:0] n_active;
    // ring limit, out of range values mean a full ring
    logic [vma_pkg::LIM_W-1:0] ring_lim;

    always_comb
    begin
        if (speaker_count_reg == '0)
            n_active = 4'd1;
        else if ({28'd0, speaker_count_reg} > SPEAKERS)
            n_active = vma_pkg::CNT_W'(SPEAKERS);
        else
            n_active = speaker_count_reg;

        if (ring_size_reg == '0 || ring_size_reg > vma_pkg::RING_FULL)
            ring_lim = vma_pkg::RING_FULL;
        else
            ring_lim = ring_size_reg;
    end

    // ---------------- input unpacking ----------------
    vma_pkg::req_t                     in_req;
    logic [vma_pkg::FRAME_W-1:0]       in_frame;
    logic [AW-1:0]                     in_addr;
    logic                              in_frame_ok;
    logic                              in_accept;

    assign in_req   = vma_pkg::req_t'(s_tuser[1:0]);
    assign in_frame = s_tdata[10:0];
    // frame compare and address over a width that always holds FRAMES
    logic [vma_pkg::LIM_W-1:0] in_frame_wide;
    assign in_frame_wide = {6'd0, in_frame};
    assign in_addr       = in_frame_wide[AW-1:0];
    assign in_frame_ok   = ({15'd0, in_frame_wide} < FRAMES);
    assign in_accept     = s_tvalid && s_tready;

    // ---------------- mix store ----------------
    logic [ROW_W-1:0] mem [FRAMES];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[in_addr];
    end

    // payload held for the write-back cycle of a mix
    logic [AW-1:0]                addr_reg;
    logic signed [vma_pkg::SAMPLE_W-1:0] left_reg;
    logic signed [vma_pkg::SAMPLE_W-1:0] right_reg;
    logic [63:0]                  vols_reg;
    logic                         eight_reg;
    logic                         stereo_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            addr_reg   <= in_addr;
            left_reg   <= s_tdata[26:11];
            right_reg  <= s_tdata[42:27];
            vols_reg   <= s_tdata[106:43];
            eight_reg  <= s_tuser[2];
            stereo_reg <= s_tuser[3];
        end
    end

    // ---------------- mix datapath, one lane per speaker ----------------
    logic [ROW_W-1:0] mix_row;

    for (genvar k = 0; k < SPEAKERS; k++)
    begin : g_lane
        logic signed [vma_pkg::SAMPLE_W-1:0] smp;
        logic [vma_pkg::VOL_W-1:0]           vol;
        logic signed [vma_pkg::PROD_W-1:0]   prod;
        logic signed [vma_pkg::PROD_W-1:0]   scl;
        logic signed [vma_pkg::ACC_W-1:0]    acc;
        logic signed [vma_pkg::ACC_W:0]      sum;
        logic                                lane_on;
        logic [vma_pkg::ACC_W-1:0]           res;

        assign smp  = (stereo_reg && k == 1) ? right_reg : left_reg;
        assign vol  = vols_reg[8*k +: 8];
        assign prod = vma_pkg::PROD_W'($signed({1'b0, vol})) * vma_pkg::PROD_W'(smp);
        // 16-bit sources: arithmetic shift gives floor division by 256
        assign scl  = eight_reg ? prod : (prod >>> 8);
        assign acc  = rd_data_reg[32*k +: 32];
        assign sum  = {acc[31], acc} + {{8{scl[vma_pkg::PROD_W-1]}}, scl};
        assign lane_on = stereo_reg ? (k < 2) : (k < n_active);

        always_comb
        begin
            if (!lane_on)
                res = acc;
            else if (sum[32] != sum[31])
                res = sum[32] ? vma_pkg::ACC_MIN : vma_pkg::ACC_MAX;
            else
                res = sum[31:0];
        end

        assign mix_row[32*k +: 32] = res;
    end

    // ---------------- drain datapath ----------------
    logic [vma_pkg::ACC_W-1:0] row_word [SPEAKERS];
    for (genvar k = 0; k < SPEAKERS; k++)
    begin : g_word
        assign row_word[k] = rd_data_reg[32*k +: 32];
    end

    state_t                     state_reg;
    logic [vma_pkg::SPK_W-1:0]  spk_reg;
    logic [vma_pkg::RING_W-1:0] ring_pos_reg;
    logic                       m_valid_reg;
    logic                       m_last_reg;
    logic [vma_pkg::SAMPLE_W-1:0] m_sample_reg;
    logic [vma_pkg::RING_W-1:0] m_index_reg;
    logic [vma_pkg::SPK_W-1:0]  m_spk_reg;

    logic signed [vma_pkg::ACC_W-1:0] drain_v;
    logic [vma_pkg::SAMPLE_W-1:0]     clip_v;
    logic [vma_pkg::SAMPLE_W-1:0]     out_v;
    logic [vma_pkg::LIM_W-1:0]        pos;
    logic [vma_pkg::LIM_W-1:0]        pos_inc;
    logic                             spk_last;
    logic                             out_free;

    always_comb
    begin
        drain_v = row_word[spk_reg[SW-1:0]];
        if (drain_v > 32'sd32767)
            clip_v = vma_pkg::CLIP_MAX;
        else if (drain_v < -32'sd32768)
            clip_v = vma_pkg::CLIP_MIN;
        else
            clip_v = drain_v[15:0];
        // 8-bit mode: (v >> 8) + 128 flips the sign bit of the high byte
        out_v = out_16bit_reg ? clip_v : {8'd0, ~clip_v[15], clip_v[14:8]};

        // restart at zero if the ring shrank below the position
        pos      = ({1'b0, ring_pos_reg} >= ring_lim) ? '0 : {1'b0, ring_pos_reg};
        pos_inc  = pos + 17'd1;
        spk_last = ({1'b0, spk_reg} + 4'd1 == n_active);
        out_free = !m_valid_reg || m_tready;
    end

    // ---------------- memory port control ----------------
    always_comb
    begin
        rd_en   = in_accept && in_frame_ok &&
                  (in_req == vma_pkg::REQ_MIX || in_req == vma_pkg::REQ_DRAIN);
        wr_en   = 1'b0;
        wr_addr = in_addr;
        wr_data = '0;
        if (state_reg == ST_MIX)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = mix_row;
        end
        else if (in_accept && in_frame_ok && in_req == vma_pkg::REQ_CLEAR)
        begin
            wr_en = 1'b1;
        end
    end

    // ---------------- sequencer and output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            spk_reg      <= '0;
            ring_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
            m_sample_reg <= '0;
            m_index_reg  <= '0;
            m_spk_reg    <= '0;
        end
        else
        begin
            // while emitting, a taken sample is replaced by the next one below
            if (m_valid_reg && m_tready && state_reg != ST_EMIT)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && in_frame_ok)
                    begin
                        if (in_req == vma_pkg::REQ_MIX)
                            state_reg <= ST_MIX;
                        else if (in_req == vma_pkg::REQ_DRAIN)
                        begin
                            state_reg <= ST_EMIT;
                            spk_reg   <= '0;
                        end
                    end
                end
                ST_MIX:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= out_v;
                        m_index_reg  <= pos[vma_pkg::RING_W-1:0];
                        m_spk_reg    <= spk_reg;
                        m_last_reg   <= spk_last;
                        ring_pos_reg <= (pos_inc >= ring_lim) ? '0
                                                              : pos_inc[vma_pkg::RING_W-1:0];
                        spk_reg      <= spk_reg + 3'd1;
                        if (spk_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_spk_reg, m_index_reg, m_sample_reg};

endmodule

`default_nettype wire

### rtl/vma_checker.sv
// port-level assertions of the voice mix accumulator and their bind
`default_nettype none

module vma_checker #(
    parameter int FRAMES = 2048
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic [vma_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic [vma_pkg::S_TUSER_W-1:0]   s_tuser,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [vma_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready
);

    logic work_req;
    assign work_req = s_tvalid && s_tready && ({21'd0, s_tdata[10:0]} < FRAMES) &&
                      (s_tuser[1:0] == vma_pkg::REQ_MIX || s_tuser[1:0] == vma_pkg::REQ_DRAIN);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // a mix or drain occupies the row port, so the next cycle takes no request
    a_busy_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        work_req |=> !s_tready)
        else $error("request taken during read-modify-write");

    // inside a frame the next speaker follows at once
    a_frame_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("drained frame broken up");

endmodule

bind voice_mix_accumulator vma_checker #(.FRAMES(FRAMES)) u_vma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

### verif/vma_drain_checker.sv
// checker of the voice mix accumulator: predicts the mix store and compares drained samples
module vma_drain_checker
    import vma_pkg::*;
#(
    parameter int FRAMES   = 2048,
    parameter int SPEAKERS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [RING_W-1:0]   ring_idx;
        logic [SPK_W-1:0]    spk;
        logic                last;
    } drain_beat_t;

    logic signed [ACC_W-1:0] acc_store [FRAMES*SPEAKERS];
    drain_beat_t             drain_beats_q [$];
    logic [CNT_W-1:0]        speaker_cnt;
    logic                    out16;
    logic [LIM_W-1:0]        ring_len;
    int                      ring_pos;

    function automatic int active_count();
        if (speaker_cnt == 0)
            return 1;
        if (speaker_cnt > SPEAKERS)
            return SPEAKERS;
        return int'(speaker_cnt);
    endfunction

    function automatic int ring_limit();
        if (ring_len == 0 || ring_len > RING_FULL)
            return 65536;
        return int'(ring_len);
    endfunction

    // volume times sample, floor shift by 8 for 16-bit sources
    function automatic longint scaled_product(logic [63:0] vols, int spk,
                                              logic signed [SAMPLE_W-1:0] smp, logic eight);
        longint prod;
        prod = longint'(vols[spk*VOL_W +: VOL_W]) * longint'(smp);
        return eight ? prod : (prod >>> 8);
    endfunction

    task automatic sat_accumulate(int slot, longint add);
        longint sum;
        sum = longint'(acc_store[slot]) + add;
        if (sum > SAT_HI)
            sum = SAT_HI;
        else if (sum < SAT_LO)
            sum = SAT_LO;
        acc_store[slot] = sum[ACC_W-1:0];
    endtask

    task automatic drain_frame(int base);
        int          n;
        int          lim;
        int          k;
        int          v;
        int          o;
        drain_beat_t beat;
        n   = active_count();
        lim = ring_limit();
        for (k = 0; k < n; k++)
        begin
            v = acc_store[base + k];
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            o = out16 ? v : (v >>> 8) + 128;
            if (ring_pos >= lim)
                ring_pos = 0;
            beat.sample   = o[SAMPLE_W-1:0];
            beat.ring_idx = ring_pos[RING_W-1:0];
            beat.spk      = k[SPK_W-1:0];
            beat.last     = (k == n - 1);
            drain_beats_q.push_back(beat);
            ring_pos = (ring_pos + 1 >= lim) ? 0 : ring_pos + 1;
        end
    endtask

    task automatic predict_request();
        req_t                       req;
        int                         base;
        int                         k;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [63:0]                vols;
        logic                       eight;
        logic                       stereo;
        req    = req_t'(s_tuser[1:0]);
        eight  = s_tuser[2];
        stereo = s_tuser[3];
        base   = int'(s_tdata[FRAME_W-1:0]) * SPEAKERS;
        left   = s_tdata[26:11];
        right  = s_tdata[42:27];
        vols   = s_tdata[106:43];
        case (req)
            REQ_CLEAR:
                for (k = 0; k < SPEAKERS; k++)
                    acc_store[base + k] = '0;
            REQ_MIX:
                if (stereo)
                begin
                    sat_accumulate(base, scaled_product(vols, 0, left, eight));
                    sat_accumulate(base + 1, scaled_product(vols, 1, right, eight));
                end
                else
                begin
                    for (k = 0; k < active_count(); k++)
                        sat_accumulate(base + k, scaled_product(vols, k, left, eight));
                end
            REQ_DRAIN:
                drain_frame(base);
            default:
                ;
        endcase
    endtask

    task automatic check_output();
        drain_beat_t want;
        if (drain_beats_q.size() == 0)
        begin
            $display("%0t: unexpected output transaction, expected none actual %h last %b",
                     $time, m_tdata, m_tlast);
            fail_count++;
        end
        else
        begin
            want = drain_beats_q.pop_front();
            if (m_tdata[15:0] !== want.sample)
            begin
                $display("%0t: out_sample mismatch, expected %h actual %h",
                         $time, want.sample, m_tdata[15:0]);
                fail_count++;
            end
            if (m_tdata[31:16] !== want.ring_idx)
            begin
                $display("%0t: out_index mismatch, expected %0d actual %0d",
                         $time, want.ring_idx, m_tdata[31:16]);
                fail_count++;
            end
            if (m_tdata[34:32] !== want.spk)
            begin
                $display("%0t: speaker mismatch, expected %0d actual %0d",
                         $time, want.spk, m_tdata[34:32]);
                fail_count++;
            end
            if (m_tlast !== want.last)
            begin
                $display("%0t: last mismatch, expected %b actual %b",
                         $time, want.last, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            speaker_cnt = 4'd2;
            out16       = 1'b1;
            ring_len    = RING_FULL;
            ring_pos    = 0;
            fail_count  = 0;
            drain_beats_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SPEAKER_COUNT: speaker_cnt = cfg_data[CNT_W-1:0];
                    CFG_OUT_16BIT:     out16 = cfg_data[0];
                    CFG_RING_SIZE:     ring_len = cfg_data;
                    default:           ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_output();
            if (s_tvalid && s_tready)
                predict_request();
        end
        pending = drain_beats_q.size();
    end

endmodule

### verif/tb_voice_mix_accumulator.sv
// testbench top of the voice mix accumulator: stimulus, handshake pacing and verdict
module tb_voice_mix_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import vma_pkg::*;

    localparam int POOL_N         = 12;     // frames the random traffic works on
    localparam int RAND_PER_PHASE = 9;      // counted requests per register setting
    localparam int SETTLE_CYCLES  = 8;      // covers the mix write back
    localparam int STALL_LIMIT    = 2000;   // cycles without any transaction
    localparam int N_SETTINGS     = 8;

    // register settings walked by the random phases, out of range values included
    int set_spk  [N_SETTINGS] = '{1, 0, 15, 9, 4, 3, 8, 2};
    int set_o16  [N_SETTINGS] = '{0, 1, 0, 1, 1, 0, 0, 1};
    int set_ring [N_SETTINGS] = '{5, 3, 1, 0, 100000, 7, 131071, 65536};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    // s_tdata: frame_index, sample_left, sample_right, volumes_packed, zero pad
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // s_tuser: req_type, source_8bit, source_stereo
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // m_tdata: out_sample, out_index, speaker, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int frame_pool [POOL_N];
    bit frame_cleared [2048];
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int rx_run      = 0;
    bit rx_hold     = 1'b0;

    always #5 clk = ~clk;

    voice_mix_accumulator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    vma_drain_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // receiver back pressure: equal windows that rotate between always ready,
    // sparse random stalls and long runs of stall or ready
    always @(posedge clk)
    begin
        case ((rx_cycle / 150) % 3)
            0:
                m_tready <= 1'b1;
            1:
                m_tready <= ($urandom_range(0, 9) < 7);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_hold = 1'($urandom_range(0, 1));
                    rx_run  = $urandom_range(1, 8);
                end
                m_tready <= rx_hold;
                rx_run--;
            end
        endcase
        rx_cycle++;
    end

    // watchdog: any transaction on either stream or a config write counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // present one request and hold it until the transaction completes; called and
    // returning at a rising edge. after each burst the sender may go quiet for a while
    task automatic send_request(req_t req, int frame, logic [15:0] left, logic [15:0] right,
                                bit eight, bit stereo, logic [63:0] vols);
        int gap;
        s_tdata  <= {5'b0, vols, right, left, frame[FRAME_W-1:0]};
        s_tuser  <= {stereo, eight, req};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (req == REQ_CLEAR)
            frame_cleared[frame] = 1'b1;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // stop sending, wait for every predicted sample, then let a mix write back land;
    // the first falling edge lets the checker book the last transaction
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers change only while the block is idle
    task automatic apply_setting(int spk, int o16, int ring);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPEAKER_COUNT;
        cfg_data  <= CFG_DATA_W'(spk);
        @(posedge clk);
        cfg_index <= CFG_OUT_16BIT;
        cfg_data  <= CFG_DATA_W'(o16);
        @(posedge clk);
        cfg_index <= CFG_RING_SIZE;
        cfg_data  <= CFG_DATA_W'(ring);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random request on the frame pool; a frame is always cleared before it is
    // mixed or drained so no never-written store row is read. ignored requests
    // (unknown kind) do not count toward the phase length
    task automatic send_random_item(output bit counted);
        int          frame;
        int          pick;
        logic [15:0] left;
        logic [15:0] right;
        bit          eight;
        bit          stereo;
        logic [63:0] vols;
        frame  = frame_pool[$urandom_range(0, POOL_N - 1)];
        pick   = $urandom_range(0, 99);
        eight  = 1'($urandom_range(0, 1));
        stereo = ($urandom_range(0, 3) == 0);
        left   = 16'($urandom);
        right  = 16'($urandom);
        vols   = {$urandom, $urandom};
        // 8-bit sources mostly carry 8-bit range samples
        if (eight && $urandom_range(0, 2) != 0)
        begin
            left  = 16'($urandom_range(0, 255) - 128);
            right = 16'($urandom_range(0, 255) - 128);
        end
        if ($urandom_range(0, 4) == 0)
            vols = '1;
        counted = 1'b1;
        if (!frame_cleared[frame] || pick < 12)
            send_request(REQ_CLEAR, frame, left, right, eight, stereo, vols);
        else if (pick < 60)
            send_request(REQ_MIX, frame, left, right, eight, stereo, vols);
        else if (pick < 92)
            send_request(REQ_DRAIN, frame, left, right, eight, stereo, vols);
        else
        begin
            send_request(REQ_NONE, frame, left, right, eight, stereo, vols);
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int n_items;
        int p;
        int k;
        bit counted;
        frame_pool[0] = 0;
        frame_pool[1] = 1;
        frame_pool[2] = 2047;
        frame_pool[3] = 1024;
        for (k = 4; k < POOL_N; k++)
            frame_pool[k] = $urandom_range(0, 2047);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // traffic on the reset register values
        n_items = 0;
        while (n_items < 10)
        begin
            send_random_item(counted);
            n_items += counted;
        end

        // directed part: all eight speakers, 16-bit output
        apply_setting(8, 1, 65536);
        send_request(REQ_CLEAR, 0, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        send_request(REQ_CLEAR, 2047, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        send_request(REQ_CLEAR, 5, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        // mono 16-bit extremes, then a negative product that must round down
        send_request(REQ_MIX, 0, 16'h7fff, 16'h0, 1'b0, 1'b0, '1);
        send_request(REQ_MIX, 0, 16'h8000, 16'h0, 1'b0, 1'b0, 64'h0102_0408_1020_4080);
        send_request(REQ_MIX, 0, 16'hffff, 16'h0, 1'b0, 1'b0, '1);
        send_request(REQ_DRAIN, 0, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        // stereo feed plus 8-bit mono on the top frame, speaker 0 clips low
        send_request(REQ_MIX, 2047, 16'h8000, 16'h7fff, 1'b0, 1'b1, '1);
        send_request(REQ_MIX, 2047, 16'h007f, 16'h0, 1'b1, 1'b0, '1);
        send_request(REQ_MIX, 2047, 16'hff80, 16'h0, 1'b1, 1'b0, 64'h00ff_00ff_00ff_00ff);
        send_request(REQ_DRAIN, 2047, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        // 8-bit stereo, zero volume, and an unknown request that must change nothing
        send_request(REQ_MIX, 5, 16'h007f, 16'hff80, 1'b1, 1'b1, '1);
        send_request(REQ_MIX, 5, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        send_request(REQ_NONE, 5, 16'hffff, 16'hffff, 1'b1, 1'b1, '1);
        send_request(REQ_DRAIN, 5, 16'h0, 16'h0, 1'b0, 1'b0, '0);
        // a cleared frame drains as zeros
        send_request(REQ_CLEAR, 0, 16'hffff, 16'hffff, 1'b1, 1'b1, '1);
        send_request(REQ_DRAIN, 0, 16'h0, 16'h0, 1'b0, 1'b0, '0);

        // random phases, each on its own register setting; the small rings start
        // while the ring position is already past them
        for (p = 0; p < N_SETTINGS; p++)
        begin
            apply_setting(set_spk[p], set_o16[p], set_ring[p]);
            n_items = 0;
            while (n_items < RAND_PER_PHASE)
            begin
                send_random_item(counted);
                n_items += counted;
                // one mid-phase pause until every sample is out
                if (p == 2 && n_items == 6 && counted)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/vma_pkg.sv
rtl/voice_mix_accumulator.sv
rtl/vma_checker.sv
verif/vma_drain_checker.sv
verif/tb_voice_mix_accumulator.sv
